// ----- rtl/dtbd_pkg.sv -----
// ----------------------------------------------------------------------------
// Dual tone detector package
// Shared widths, filter coefficients and the types passed between the
// filter sequencer and the window unit.
// ----------------------------------------------------------------------------
package dtbd_pkg;

    localparam int SAMPLE_W   = 10;   // input sample width
    localparam int FILT_W     = 16;   // filtered output / window entry width
    localparam int DATA_W     = 32;   // history word and accumulator width
    localparam int FRAC_W     = 16;   // Q16 coefficients
    localparam int COEF_W     = 18;   // signed coefficient width
    localparam int THR_W      = 16;   // threshold register width
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TERMS      = 5;    // b0, b1, b2, -a1, -a2
    localparam int ROWS       = 4;
    localparam int TERM_W     = $clog2(TERMS);
    localparam int ROW_W      = $clog2(ROWS);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THR_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_HIGH = 2'd1;

    localparam logic [THR_W-1:0] THR_LOW_RST  = 16'd80;
    localparam logic [THR_W-1:0] THR_HIGH_RST = 16'd90;

    // Tone selector
    localparam logic TONE_LOW  = 1'b0;
    localparam logic TONE_HIGH = 1'b1;

    // Coefficient table [tone][row][term]; feedback terms are stored negated
    // so that every product is added.
    localparam logic signed [COEF_W-1:0] COEF [2][ROWS][TERMS] = '{
        '{
            '{18'sd513, 18'sd0, -18'sd513, 18'sd119780, -18'sd65136},
            '{18'sd513, 18'sd0, -18'sd513, 18'sd120540, -18'sd65150},
            '{18'sd511, 18'sd0, -18'sd511, 18'sd119498, -18'sd64585},
            '{18'sd511, 18'sd0, -18'sd511, 18'sd119819, -18'sd64598}
        },
        '{
            '{18'sd627, 18'sd0, -18'sd627, 18'sd114439, -18'sd65048},
            '{18'sd627, 18'sd0, -18'sd627, 18'sd115547, -18'sd65064},
            '{18'sd624, 18'sd0, -18'sd624, 18'sd114177, -18'sd64375},
            '{18'sd624, 18'sd0, -18'sd624, 18'sd114642, -18'sd64391}
        }
    };

    // Push request into the window unit
    typedef struct packed {
        logic                     push;
        logic                     tone;
        logic signed [FILT_W-1:0] value;
    } t_win_req;

    // Window unit status
    typedef struct packed {
        logic busy;
        logic low_det;
        logic high_det;
    } t_win_stat;

endpackage

// ----- rtl/dtbd_sample_if.sv -----
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one audio sample per request.
// ----------------------------------------------------------------------------
interface dtbd_sample_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [dtbd_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

// ----- rtl/dtbd_result_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the detect flags and both filter outputs.
// ----------------------------------------------------------------------------
interface dtbd_result_if;

    logic                               valid;
    logic                               ready;
    logic                               low_tone_present;
    logic                               high_tone_present;
    logic signed [dtbd_pkg::FILT_W-1:0] low_filtered;
    logic signed [dtbd_pkg::FILT_W-1:0] high_filtered;

    modport source (
        output valid, output low_tone_present, output high_tone_present,
        output low_filtered, output high_filtered, input ready
    );
    modport sink (
        input valid, input low_tone_present, input high_tone_present,
        input low_filtered, input high_filtered, output ready
    );

endinterface

// ----- rtl/dtbd_window.sv -----
// ----------------------------------------------------------------------------
// Tone window unit
// Holds both tone windows as circular buffers in one memory. A push writes
// the new entry, then a scan reads the tone's window one entry a cycle and
// compares its peak-to-peak span with the threshold.
// ----------------------------------------------------------------------------
module dtbd_window #(
    parameter int LOW_WINDOW_LEN  = 15,
    parameter int HIGH_WINDOW_LEN = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [dtbd_pkg::THR_W-1:0]    i_thr_low,
    input  logic [dtbd_pkg::THR_W-1:0]    i_thr_high,
    input  dtbd_pkg::t_win_req            i_req,
    output dtbd_pkg::t_win_stat           o_stat
);

    localparam int WIN_DEPTH = LOW_WINDOW_LEN + HIGH_WINDOW_LEN;
    localparam int WA_W      = $clog2(WIN_DEPTH);
    localparam int MAX_LEN   = (LOW_WINDOW_LEN > HIGH_WINDOW_LEN) ?
                               LOW_WINDOW_LEN : HIGH_WINDOW_LEN;
    localparam int CNT_W     = $clog2(MAX_LEN);
    localparam int LH_W      = $clog2(LOW_WINDOW_LEN);
    localparam int HH_W      = $clog2(HIGH_WINDOW_LEN);
    localparam int FW        = dtbd_pkg::FILT_W;

    localparam logic [1:0] WS_CLEAR  = 2'd0;
    localparam logic [1:0] WS_IDLE   = 2'd1;
    localparam logic [1:0] WS_SCAN   = 2'd2;
    localparam logic [1:0] WS_DECIDE = 2'd3;

    logic [1:0]             r_state;
    logic [WA_W-1:0]        r_clr;
    logic                   r_tone;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_issue;
    logic                   r_rd_v;
    logic                   r_rd_last;
    logic signed [FW-1:0]   r_rdata;
    logic signed [FW-1:0]   r_max;
    logic signed [FW-1:0]   r_min;
    logic                   r_low_det;
    logic                   r_high_det;
    logic [LH_W-1:0]        r_low_head;
    logic [HH_W-1:0]        r_high_head;
    logic signed [FW-1:0]   r_win [WIN_DEPTH];

    logic                   win_we;
    logic [WA_W-1:0]        win_waddr;
    logic signed [FW-1:0]   win_wdata;
    logic [WA_W-1:0]        win_raddr;
    logic [WA_W-1:0]        scan_base;
    logic [CNT_W-1:0]       scan_last;
    logic [WA_W-1:0]        push_addr;
    logic                   push_ok;
    logic signed [FW:0]     span;
    logic                   over;
    logic [dtbd_pkg::THR_W-1:0] thr_sel;

    assign push_ok = (r_state == WS_IDLE) && i_req.push;

    // Window region and length of the tone under scan
    assign scan_base = (r_tone == dtbd_pkg::TONE_HIGH) ? WA_W'(LOW_WINDOW_LEN) : '0;
    assign scan_last = (r_tone == dtbd_pkg::TONE_HIGH) ? CNT_W'(HIGH_WINDOW_LEN - 1)
                                                       : CNT_W'(LOW_WINDOW_LEN - 1);
    assign win_raddr = scan_base + WA_W'(r_cnt);

    // Slot for the new entry
    assign push_addr = (i_req.tone == dtbd_pkg::TONE_HIGH) ?
                       WA_W'(LOW_WINDOW_LEN) + WA_W'(r_high_head) : WA_W'(r_low_head);

    // Peak-to-peak span; max is never below zero and min never above
    assign span    = {r_max[FW-1], r_max} - {r_min[FW-1], r_min};
    assign thr_sel = (r_tone == dtbd_pkg::TONE_HIGH) ? i_thr_high : i_thr_low;
    assign over    = span[FW-1:0] > thr_sel;

    // Memory write selection
    always_comb begin
        win_we    = 1'b0;
        win_waddr = r_clr;
        win_wdata = '0;
        if (r_state == WS_CLEAR) begin
            win_we = 1'b1;
        end else if (push_ok) begin
            win_we    = 1'b1;
            win_waddr = push_addr;
            win_wdata = i_req.value;
        end
    end

    // Window memory
    always_ff @(posedge i_clk) begin
        if (win_we) begin
            r_win[win_waddr] <= win_wdata;
        end
        r_rdata <= r_win[win_raddr];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= WS_CLEAR;
            r_clr       <= '0;
            r_issue     <= 1'b0;
            r_rd_v      <= 1'b0;
            r_rd_last   <= 1'b0;
            r_low_det   <= 1'b0;
            r_high_det  <= 1'b0;
            r_low_head  <= '0;
            r_high_head <= '0;
            r_cnt       <= '0;
            r_tone      <= dtbd_pkg::TONE_LOW;
        end else begin
            unique case (r_state)
                WS_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == WA_W'(WIN_DEPTH - 1)) begin
                        r_state <= WS_IDLE;
                    end
                end
                WS_IDLE: begin
                    if (push_ok) begin
                        r_tone    <= i_req.tone;
                        r_cnt     <= '0;
                        r_issue   <= 1'b1;
                        r_rd_v    <= 1'b0;
                        r_rd_last <= 1'b0;
                        r_max     <= '0;
                        r_min     <= '0;
                        if (i_req.tone == dtbd_pkg::TONE_HIGH) begin
                            r_high_head <= (r_high_head == HH_W'(HIGH_WINDOW_LEN - 1)) ?
                                           '0 : r_high_head + 1'b1;
                        end else begin
                            r_low_head <= (r_low_head == LH_W'(LOW_WINDOW_LEN - 1)) ?
                                          '0 : r_low_head + 1'b1;
                        end
                        r_state <= WS_SCAN;
                    end
                end
                WS_SCAN: begin
                    // issue one read a cycle, fold returned entries
                    if (r_issue) begin
                        if (r_cnt == scan_last) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                    end
                    r_rd_v    <= r_issue;
                    r_rd_last <= r_issue && (r_cnt == scan_last);
                    if (r_rd_v) begin
                        if (r_rdata > r_max) begin
                            r_max <= r_rdata;
                        end
                        if (r_rdata < r_min) begin
                            r_min <= r_rdata;
                        end
                    end
                    if (r_rd_last) begin
                        r_state <= WS_DECIDE;
                    end
                end
                WS_DECIDE: begin
                    if (r_tone == dtbd_pkg::TONE_HIGH) begin
                        r_high_det <= over;
                    end else begin
                        r_low_det <= over;
                    end
                    r_state <= WS_IDLE;
                end
                default: begin
                    r_state <= WS_IDLE;
                end
            endcase
        end
    end

    assign o_stat.busy     = (r_state != WS_IDLE);
    assign o_stat.low_det  = r_low_det;
    assign o_stat.high_det = r_high_det;

endmodule

// ----- rtl/dual_tone_biquad_detector.sv -----
// ----------------------------------------------------------------------------
// Dual tone biquad detector
// Two cascaded-biquad bandpass filters (900 Hz and 1100 Hz) sharing one
// multiplier and one history memory, followed by peak-to-peak tone windows.
// ----------------------------------------------------------------------------
// One sample yields one result. Each filter first shifts the input stage, then
// runs each biquad section in turn (five multiply-accumulates on the single
// shared multiplier and two reads of the history memory, which has one read
// port), then pushes its output into the window unit, and the 1100 Hz window
// is then scanned one entry a cycle. The 900 Hz window scan runs under the
// 1100 Hz filter and only delays the 1100 Hz push while it is still busy.
// The next sample can be taken in the cycle after a result is loaded; a new
// sample is taken while the previous result still waits in the output
// register. After reset both memories are cleared, one entry a cycle; the
// first sample is accepted once the history memory is clear and pushed once
// the window memory is; threshold writes are taken throughout.
// ----------------------------------------------------------------------------
module dual_tone_biquad_detector #(
    parameter int SECTIONS        = 4,
    parameter int LOW_WINDOW_LEN  = 15,
    parameter int HIGH_WINDOW_LEN = 10
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dtbd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [dtbd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    dtbd_sample_if.sink                       i_sample_ch,
    dtbd_result_if.source                     o_result_ch
);

    localparam int STG_W = $clog2(SECTIONS + 1);
    localparam int HA_W  = STG_W + 2;            // {filter, stage, tap}
    localparam int HIST_DEPTH = 2 ** HA_W;
    localparam int DW    = dtbd_pkg::DATA_W;
    localparam int FW    = dtbd_pkg::FILT_W;
    localparam int SW    = dtbd_pkg::SAMPLE_W;
    localparam int CW    = dtbd_pkg::COEF_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_PUSH  = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [2:0] STEP_SHIFT_LAST = 3'd3;
    localparam logic [2:0] STEP_SECT_LAST  = 3'd5;
    localparam logic [2:0] STEP_TAP2       = 3'd2;

    localparam logic [STG_W-1:0] STG_MAX = STG_W'(SECTIONS);

    // Control state
    logic [2:0]                  r_state;
    logic [HA_W-1:0]             r_clr;
    logic                        r_filt;
    logic [STG_W-1:0]            r_stage;
    logic [2:0]                  r_step;
    logic                        r_out_valid;
    logic [dtbd_pkg::THR_W-1:0]  r_thr_low;
    logic [dtbd_pkg::THR_W-1:0]  r_thr_high;

    // Datapath
    logic signed [SW-1:0]        r_sample;
    logic [DW-1:0]               r_x0;
    logic [DW-1:0]               r_x1;
    logic [DW-1:0]               r_x2;
    logic [DW-1:0]               r_y1;
    logic [DW-1:0]               r_y2;
    logic [DW-1:0]               r_prod;
    logic [DW-1:0]               r_acc;
    logic [DW-1:0]               r_hist_rd;
    logic [DW-1:0]               r_hist [HIST_DEPTH];
    logic signed [FW-1:0]        r_lo_val;
    logic signed [FW-1:0]        r_hi_val;
    logic                        r_out_lo_det;
    logic                        r_out_hi_det;
    logic signed [FW-1:0]        r_out_lo;
    logic signed [FW-1:0]        r_out_hi;

    logic                        in_acc;
    logic                        out_free;
    logic                        out_load;
    logic [2:0]                  step_end;
    logic [HA_W-1:0]             hist_raddr;
    logic                        hist_we;
    logic [HA_W-1:0]             hist_waddr;
    logic [DW-1:0]               hist_wdata;
    logic [dtbd_pkg::ROW_W-1:0]  coef_row;
    logic [dtbd_pkg::TERM_W-1:0] coef_term;
    logic signed [CW-1:0]        coef_sel;
    logic [DW-1:0]               mul_op;
    logic signed [CW+DW-1:0]     mul_full;
    logic [DW-1:0]               sum;
    logic [DW-1:0]               sect_y;
    logic [DW-1:0]               new_val;

    dtbd_pkg::t_win_req          s_win_req;
    dtbd_pkg::t_win_stat         s_win_stat;

    assign in_acc   = i_sample_ch.valid && i_sample_ch.ready;
    assign out_free = !r_out_valid || o_result_ch.ready;
    assign out_load = (r_state == ST_FIN) && !s_win_stat.busy && out_free;
    assign step_end = (r_stage == '0) ? STEP_SHIFT_LAST : STEP_SECT_LAST;

    // Threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_low  <= dtbd_pkg::THR_LOW_RST;
            r_thr_high <= dtbd_pkg::THR_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dtbd_pkg::CFG_THR_LOW:  r_thr_low  <= i_cfg_data;
                dtbd_pkg::CFG_THR_HIGH: r_thr_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Coefficient and operand for this step; section s uses row s mod 4
    assign coef_row  = dtbd_pkg::ROW_W'(r_stage - 1'b1);
    assign coef_term = (r_step > 3'd4) ? '0 : dtbd_pkg::TERM_W'(r_step);
    assign coef_sel  = dtbd_pkg::COEF[r_filt][coef_row][coef_term];

    always_comb begin
        unique case (r_step)
            3'd0:    mul_op = r_x0;
            3'd1:    mul_op = r_x1;
            3'd2:    mul_op = r_x2;
            3'd3:    mul_op = r_y1;
            3'd4:    mul_op = r_y2;
            default: mul_op = r_x0;
        endcase
    end

    assign mul_full = coef_sel * $signed(mul_op);

    // Section output: wrapped sum, arithmetic shift by the Q16 point
    assign sum     = r_acc + r_prod;
    assign sect_y  = {{dtbd_pkg::FRAC_W{sum[DW-1]}}, sum[DW-1:dtbd_pkg::FRAC_W]};
    assign new_val = (r_stage == '0) ? {{(DW - SW){r_sample[SW-1]}}, r_sample} : sect_y;

    // History addressing: tap 0 at step 0, tap 1 at step 1
    assign hist_raddr = {r_filt, r_stage, (r_step == 3'd1)};

    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = r_clr;
        hist_wdata = '0;
        if (r_state == ST_CLEAR) begin
            hist_we = 1'b1;
        end else if (r_state == ST_RUN) begin
            if (r_step == STEP_TAP2) begin
                hist_we    = 1'b1;
                hist_waddr = {r_filt, r_stage, 1'b1};
                hist_wdata = r_y1;
            end else if (r_step == step_end) begin
                hist_we    = 1'b1;
                hist_waddr = {r_filt, r_stage, 1'b0};
                hist_wdata = new_val;
            end
        end
    end

    // History memory
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist[hist_waddr] <= hist_wdata;
        end
        r_hist_rd <= r_hist[hist_raddr];
    end

    // Multiply-accumulate pipeline
    always_ff @(posedge i_clk) begin
        r_prod <= mul_full[DW-1:0];
        if (r_step == 3'd1) begin
            r_acc <= r_prod;
        end else begin
            r_acc <= r_acc + r_prod;
        end
        if (r_step == 3'd1) begin
            r_y1 <= r_hist_rd;
        end
        if (r_step == 3'd2) begin
            r_y2 <= r_hist_rd;
        end
        if (in_acc) begin
            r_sample <= i_sample_ch.sample;
        end
        if (r_state == ST_RUN && r_step == step_end) begin
            r_x0 <= new_val;
            r_x1 <= r_y1;
            r_x2 <= r_y2;
            if (r_stage == STG_MAX) begin
                if (r_filt == dtbd_pkg::TONE_HIGH) begin
                    r_hi_val <= sect_y[FW-1:0];
                end else begin
                    r_lo_val <= sect_y[FW-1:0];
                end
            end
        end
    end

    // Push the finished filter output into its window
    assign s_win_req.push  = (r_state == ST_PUSH) && !s_win_stat.busy;
    assign s_win_req.tone  = r_filt;
    assign s_win_req.value = (r_filt == dtbd_pkg::TONE_HIGH) ? r_hi_val : r_lo_val;

    dtbd_window #(
        .LOW_WINDOW_LEN  (LOW_WINDOW_LEN),
        .HIGH_WINDOW_LEN (HIGH_WINDOW_LEN)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_thr_low  (r_thr_low),
        .i_thr_high (r_thr_high),
        .i_req      (s_win_req),
        .o_stat     (s_win_stat)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_filt      <= dtbd_pkg::TONE_LOW;
            r_stage     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a finished result, or drop the one just taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == HA_W'(HIST_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_filt  <= dtbd_pkg::TONE_LOW;
                        r_stage <= '0;
                        r_step  <= '0;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (r_step == step_end) begin
                        r_step <= '0;
                        if (r_stage == STG_MAX) begin
                            r_state <= ST_PUSH;
                        end else begin
                            r_stage <= r_stage + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_PUSH: begin
                    if (!s_win_stat.busy) begin
                        if (r_filt == dtbd_pkg::TONE_LOW) begin
                            r_filt  <= dtbd_pkg::TONE_HIGH;
                            r_stage <= '0;
                            r_step  <= '0;
                            r_state <= ST_RUN;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    // hold until the high window is decided and the output is free
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_lo_det <= s_win_stat.low_det;
            r_out_hi_det <= s_win_stat.high_det;
            r_out_lo     <= r_lo_val;
            r_out_hi     <= r_hi_val;
        end
    end

    assign i_sample_ch.ready             = (r_state == ST_IDLE);
    assign o_result_ch.valid             = r_out_valid;
    assign o_result_ch.low_tone_present  = r_out_lo_det;
    assign o_result_ch.high_tone_present = r_out_hi_det;
    assign o_result_ch.low_filtered      = r_out_lo;
    assign o_result_ch.high_filtered     = r_out_hi;

    // Checks
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage <= STG_MAX)
        else $error("stage index beyond last section");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RUN |-> (r_step <= STEP_SECT_LAST &&
                               (r_stage != '0 || r_step <= STEP_SHIFT_LAST)))
        else $error("step counter beyond end of stage");

    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_win_req.push |-> !s_win_stat.busy)
        else $error("window push while window unit busy");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_RUN && r_stage == '0 && r_step == '0 &&
                    r_filt == dtbd_pkg::TONE_LOW))
        else $error("request did not start the low filter");

    a_fin_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_FIN |-> r_filt == dtbd_pkg::TONE_HIGH)
        else $error("result finished before high filter ran");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual tone biquad detector testbench
// Drives audio samples through the valid/ready sample channel under bursty
// traffic and receiver stalls. Each result is checked field by field against
// an in-bench model of both biquad cascades and their peak-to-peak windows,
// across reset, extreme and random threshold settings.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SECTIONS     = 4;
    localparam int LOW_LEN      = 15;
    localparam int HIGH_LEN     = 10;
    localparam int MAX_LEN      = 15;
    localparam int RANDOM_ITEMS = 490;
    localparam int DRAIN_CYCLES = 200;
    localparam int MAX_REPORTS  = 10;

    // Indexes outside the register list; writes to them must be dropped
    localparam logic [dtbd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [dtbd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef logic signed [dtbd_pkg::SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic                               low_det;
        logic                               high_det;
        logic signed [dtbd_pkg::FILT_W-1:0] low_y;
        logic signed [dtbd_pkg::FILT_W-1:0] high_y;
    } t_tone_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [dtbd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [dtbd_pkg::CFG_DATA_W-1:0] i_cfg_data;

    dtbd_sample_if smp_if ();
    dtbd_result_if res_if ();

    dual_tone_biquad_detector #(
        .SECTIONS        (SECTIONS),
        .LOW_WINDOW_LEN  (LOW_LEN),
        .HIGH_WINDOW_LEN (HIGH_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample_ch (smp_if),
        .o_result_ch (res_if)
    );

    always #6 i_clk = ~i_clk;

    // Model state: rows are b0, b1, b2, a1, a2 with a0 = 1.0 in Q16
    int taps [2][4][5] = '{
        '{
            '{513, 0, -513, -119780, 65136},
            '{513, 0, -513, -120540, 65150},
            '{511, 0, -511, -119498, 64585},
            '{511, 0, -511, -119819, 64598}
        },
        '{
            '{627, 0, -627, -114439, 65048},
            '{627, 0, -627, -115547, 65064},
            '{624, 0, -624, -114177, 64375},
            '{624, 0, -624, -114642, 64391}
        }
    };
    logic [dtbd_pkg::DATA_W-1:0] filt_hist [2][SECTIONS + 1][3];
    logic [dtbd_pkg::FILT_W-1:0] tone_win [2][MAX_LEN];
    logic [dtbd_pkg::THR_W-1:0]  thr_model [2];

    t_tone_result pending_results [$];
    t_tone_result got_result;
    t_tone_result want_result;
    int           mismatches = 0;
    int           items_sent = 0;
    int           burst_left = 0;
    logic [7:0]   stall_tick = '0;
    logic [15:0]  stall_mask = '1;

    // Advance one cascade by one sample; every product and sum wraps at 32 bits
    function automatic logic [dtbd_pkg::FILT_W-1:0] filter_step(
        input logic tone, input logic [dtbd_pkg::DATA_W-1:0] x);
        logic [dtbd_pkg::DATA_W-1:0] acc;
        int                          s;
        int                          row;
        filt_hist[tone][0][2] = filt_hist[tone][0][1];
        filt_hist[tone][0][1] = filt_hist[tone][0][0];
        filt_hist[tone][0][0] = x;
        for (s = 0; s < SECTIONS; s++) begin
            row = s % 4;
            acc = taps[tone][row][0] * filt_hist[tone][s][0]
                + taps[tone][row][1] * filt_hist[tone][s][1]
                + taps[tone][row][2] * filt_hist[tone][s][2]
                - taps[tone][row][3] * filt_hist[tone][s + 1][0]
                - taps[tone][row][4] * filt_hist[tone][s + 1][1];
            filt_hist[tone][s + 1][2] = filt_hist[tone][s + 1][1];
            filt_hist[tone][s + 1][1] = filt_hist[tone][s + 1][0];
            filt_hist[tone][s + 1][0] = $signed(acc) >>> dtbd_pkg::FRAC_W;
        end
        return filt_hist[tone][SECTIONS][0][dtbd_pkg::FILT_W-1:0];
    endfunction

    // Push into the window, then compare its exact peak-to-peak with the threshold
    function automatic logic window_flag(input logic tone, input int len,
                                         input logic [dtbd_pkg::FILT_W-1:0] v);
        int n;
        int e;
        int hi;
        int lo;
        int limit;
        for (n = len - 1; n > 0; n--)
            tone_win[tone][n] = tone_win[tone][n - 1];
        tone_win[tone][0] = v;
        hi = 0;
        lo = 0;
        for (n = 0; n < len; n++) begin
            e = int'($signed(tone_win[tone][n]));
            if (e > hi) hi = e;
            if (e < lo) lo = e;
        end
        limit = int'(thr_model[tone]);
        return (hi - lo) > limit;
    endfunction

    function automatic t_tone_result predict_tones(input t_sample s);
        t_tone_result                r;
        logic [dtbd_pkg::DATA_W-1:0] x;
        x = {{(dtbd_pkg::DATA_W - dtbd_pkg::SAMPLE_W){s[dtbd_pkg::SAMPLE_W-1]}}, s};
        r.low_y    = filter_step(dtbd_pkg::TONE_LOW, x);
        r.high_y   = filter_step(dtbd_pkg::TONE_HIGH, x);
        r.low_det  = window_flag(dtbd_pkg::TONE_LOW, LOW_LEN, r.low_y);
        r.high_det = window_flag(dtbd_pkg::TONE_HIGH, HIGH_LEN, r.high_y);
        return r;
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $time, what);
    endfunction

    // Send one sample request in bursts with random gaps; predict on acceptance
    task automatic send_sample(input t_sample s);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100)
                                               : $urandom_range(0, 4);
            if (gap > 0) begin
                smp_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= s;
        do @(posedge i_clk); while (!smp_if.ready);
        pending_results.push_back(predict_tones(s));
        burst_left--;
        items_sent++;
    endtask

    // Hold the sender off until every outstanding result has come back
    task automatic wait_results_drained;
        smp_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write a spare index first (must be ignored), then both thresholds
    task automatic set_thresholds(input logic [dtbd_pkg::THR_W-1:0] thr_lo,
                                  input logic [dtbd_pkg::THR_W-1:0] thr_hi);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
        i_cfg_data <= 16'($urandom_range(0, 65535));
        @(posedge i_clk);
        i_cfg_idx  <= dtbd_pkg::CFG_THR_LOW;
        i_cfg_data <= thr_lo;
        @(posedge i_clk);
        i_cfg_idx  <= dtbd_pkg::CFG_THR_HIGH;
        i_cfg_data <= thr_hi;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        thr_model[dtbd_pkg::TONE_LOW]  = thr_lo;
        thr_model[dtbd_pkg::TONE_HIGH] = thr_hi;
    endtask

    function automatic logic [dtbd_pkg::THR_W-1:0] pick_threshold;
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return 16'($urandom_range(0, 400));
            4:       return 16'($urandom_range(0, 4000));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // One stretch of input: a tone burst, wideband noise or silence
    task automatic send_segment;
        int kind;
        int len;
        int period;
        int amp;
        int ph;
        int n;
        int t;
        int v;
        bit square;
        kind = $urandom_range(0, 9);
        if (kind <= 6) begin
            period = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 40)
                                                  : $urandom_range(11, 17);
            amp    = ($urandom_range(0, 2) == 0) ? 512 : $urandom_range(1, 512);
            len    = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 160)
                                                  : $urandom_range(15, 60);
            square = ($urandom_range(0, 1) == 1);
            ph     = $urandom_range(0, period - 1);
            for (n = 0; n < len; n++) begin
                t = 4 * ((ph + n) % period);
                if (square)
                    v = (t < 2 * period) ? amp : -amp;
                else if (t < period)
                    v = amp * t / period;
                else if (t < 3 * period)
                    v = amp * (2 * period - t) / period;
                else
                    v = amp * (t - 4 * period) / period;
                if (v > 511) v = 511;
                send_sample(t_sample'(v));
            end
        end else if (kind <= 8) begin
            len = $urandom_range(5, 20);
            for (n = 0; n < len; n++)
                send_sample(t_sample'($urandom_range(0, 1023)));
        end else begin
            len = $urandom_range(5, 30);
            for (n = 0; n < len; n++)
                send_sample('0);
        end
    endtask

    // Reset thresholds with input extremes and a short full-scale square
    task automatic test_directed_extremes;
        t_sample corner_vals [8];
        int      n;
        corner_vals = '{10'sd0, 10'sd511, -10'sd512, 10'sd511,
                        -10'sd512, -10'sd1, 10'sd1, 10'sd0};
        for (n = 0; n < 8; n++)
            send_sample(corner_vals[n]);
        for (n = 0; n < 8; n++)
            send_sample((n < 4) ? 10'sd511 : -10'sd512);
        wait_results_drained();
    endtask

    // Lowest thresholds flag any ripple; highest can never be exceeded
    task automatic test_threshold_extremes;
        int n;
        set_thresholds('0, '0);
        for (n = 0; n < 5; n++)
            send_sample(t_sample'($urandom_range(0, 1023)));
        wait_results_drained();
        set_thresholds('1, '1);
        for (n = 0; n < 5; n++)
            send_sample((n % 2) ? 10'sd511 : -10'sd512);
        wait_results_drained();
    endtask

    // Random phases of tone bursts and noise, fresh thresholds per phase
    task automatic test_tone_bursts;
        int start;
        int phase_start;
        int phase_len;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            set_thresholds(pick_threshold(), pick_threshold());
            phase_start = items_sent;
            phase_len   = $urandom_range(30, 70);
            while (items_sent - phase_start < phase_len)
                send_segment();
            wait_results_drained();
        end
    endtask

    // Check each accepted result and drive the receiver stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_result = '{res_if.low_tone_present, res_if.high_tone_present,
                           res_if.low_filtered, res_if.high_filtered};
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("result with none outstanding: %p", got_result));
            end else begin
                want_result = pending_results.pop_front();
                if (got_result.low_det !== want_result.low_det)
                    note_mismatch($sformatf("low_tone_present expected %0d got %0d",
                                            want_result.low_det, got_result.low_det));
                if (got_result.high_det !== want_result.high_det)
                    note_mismatch($sformatf("high_tone_present expected %0d got %0d",
                                            want_result.high_det, got_result.high_det));
                if (got_result.low_y !== want_result.low_y)
                    note_mismatch($sformatf("low_filtered expected %0d got %0d",
                                            want_result.low_y, got_result.low_y));
                if (got_result.high_y !== want_result.high_y)
                    note_mismatch($sformatf("high_filtered expected %0d got %0d",
                                            want_result.high_y, got_result.high_y));
            end
        end
        stall_tick <= stall_tick + 1'b1;
        if (stall_tick[5:0] == '0) begin
            case ($urandom_range(0, 3))
                0:       stall_mask <= '1;
                1:       stall_mask <= 16'($urandom);
                2:       stall_mask <= 16'($urandom | $urandom);
                default: stall_mask <= 16'($urandom & $urandom);
            endcase
        end
        res_if.ready <= stall_mask[stall_tick[3:0]];
    end

    initial begin
        int tone;
        int k;
        int n;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= dtbd_pkg::CFG_THR_LOW;
        i_cfg_data    <= '0;
        smp_if.valid  <= 1'b0;
        smp_if.sample <= '0;
        thr_model[dtbd_pkg::TONE_LOW]  = dtbd_pkg::THR_LOW_RST;
        thr_model[dtbd_pkg::TONE_HIGH] = dtbd_pkg::THR_HIGH_RST;
        for (tone = 0; tone < 2; tone++) begin
            for (k = 0; k <= SECTIONS; k++)
                for (n = 0; n < 3; n++)
                    filt_hist[tone][k][n] = '0;
            for (n = 0; n < MAX_LEN; n++)
                tone_win[tone][n] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_threshold_extremes();
        test_tone_bursts();

        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("dual_tone_biquad_detector: match");
        else
            $display("dual_tone_biquad_detector: mismatch");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #10_000_000;
        $display("dual_tone_biquad_detector: mismatch");
        $finish;
    end

endmodule
